/* src/sevt_pkg.sv */
// Package for the sorted event table: widths, codes, entry type and the
// controller/datapath command and status structs. No dependencies.
package sevt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = 6;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int TIME_W      = 24;
    localparam int PID_W       = 14;
    localparam int REF_W       = 16;
    localparam int KEY_W       = 38;
    localparam int KEY_SCALE   = 10000;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_QUERY = 2'd2;

    localparam logic [2:0] OUT_NONE  = 3'd0;
    localparam logic [2:0] OUT_DONE  = 3'd1;
    localparam logic [2:0] OUT_FULL  = 3'd2;
    localparam logic [2:0] OUT_COUNT = 3'd3;
    localparam logic [2:0] OUT_ENTRY = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] time_value;
        logic [PID_W-1:0]  package_id;
        logic              is_registration;
        logic [REF_W-1:0]  event_ref;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
        logic       cnt_inc;
        logic       seen_inc;
        logic       insert;
        logic       remove;
        logic [2:0] out_sel;
    } t_cmd;

    typedef struct packed {
        logic at_end;
        logic full;
        logic idx_zero;
        logic del_hit;
        logic key_lt;
        logic key_gt;
        logic time_le;
        logic out_last;
    } t_sts;

    function automatic logic [KEY_W-1:0] key_of(logic [TIME_W-1:0] t, logic [PID_W-1:0] p);
        return KEY_W'(t) * KEY_W'(KEY_SCALE) + KEY_W'(p);
    endfunction

endpackage

/* src/sevt_in_if.sv */
// Request channel of the sorted event table: valid, ready and the request fields.
// Depends on sevt_pkg.
interface sevt_in_if;
    logic                        valid;
    logic                        ready;
    logic [sevt_pkg::KIND_W-1:0] kind;
    logic [sevt_pkg::TIME_W-1:0] time_value;
    logic [sevt_pkg::PID_W-1:0]  package_id;
    logic                        is_registration;
    logic [sevt_pkg::REF_W-1:0]  event_ref;

    modport source (output valid, kind, time_value, package_id, is_registration, event_ref,
                    input ready);
    modport sink (input valid, kind, time_value, package_id, is_registration, event_ref,
                  output ready);
endinterface

/* src/sevt_out_if.sv */
// Result channel of the sorted event table: valid, ready and the result fields.
// Depends on sevt_pkg.
interface sevt_out_if;
    logic                          valid;
    logic                          ready;
    logic [sevt_pkg::STATUS_W-1:0] status;
    logic [sevt_pkg::CNT_W-1:0]    match_count;
    logic [sevt_pkg::TIME_W-1:0]   out_time;
    logic [sevt_pkg::PID_W-1:0]    out_package_id;
    logic [sevt_pkg::REF_W-1:0]    out_event_ref;
    logic                          last;

    modport source (output valid, status, match_count, out_time, out_package_id,
                    out_event_ref, last, input ready);
    modport sink (input valid, status, match_count, out_time, out_package_id,
                  out_event_ref, last, output ready);
endinterface

/* src/sorted_event_table.sv */
// Top level of the sorted event table: joins the controller and the datapath to the
// request and result channels. Depends on sevt_pkg, sevt_in_if, sevt_out_if, sevt_ctrl, sevt_datapath.
//
// The table keeps up to TABLE_DEPTH entries ordered by time*10000+package id and takes one
// request at a time. The datapath examines one stored entry per cycle while a scan runs, pausing
// while a result waits, so the work scales with the occupancy N: an insert scans for its place,
// an update scans for the entry to remove and then for the place, and a query counts its matches
// in one scan and lists them in a second scan that stops for each reported entry. Each result waits
// in the output register until its transfer completes; after the last result the next request is accepted.
module sorted_event_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sevt_in_if.sink      i_req,
    sevt_out_if.source   o_rsp
);
    import sevt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sevt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_kind      (i_req.kind),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sevt_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_time_value      (i_req.time_value),
        .i_package_id      (i_req.package_id),
        .i_is_registration (i_req.is_registration),
        .i_event_ref       (i_req.event_ref),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_status          (o_rsp.status),
        .o_match_count     (o_rsp.match_count),
        .o_out_time        (o_rsp.out_time),
        .o_out_package_id  (o_rsp.out_package_id),
        .o_out_event_ref   (o_rsp.out_event_ref),
        .o_last            (o_rsp.last)
    );

endmodule

/* src/sevt_ctrl.sv */
// Controller of the sorted event table: sequences scans, table edits and result transfers.
// Depends on sevt_pkg.
module sevt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [sevt_pkg::KIND_W-1:0] i_kind,
    output logic                        o_in_ready,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    input  sevt_pkg::t_sts              i_sts,
    output sevt_pkg::t_cmd              o_cmd
);
    import sevt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEL  = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_CNT  = 3'd3;
    localparam logic [2:0] ST_LIST = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_kind)
                        KIND_INSERT: n_state = ST_INS;
                        KIND_UPDATE: n_state = ST_DEL;
                        KIND_QUERY:  n_state = ST_CNT;
                        default: begin
                            o_cmd.out_sel = OUT_DONE;
                            n_state       = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_DEL: begin
                if (i_sts.at_end) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_INS;
                end else if (i_sts.del_hit) begin
                    o_cmd.remove  = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_INS;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_INS: begin
                if (i_sts.full) begin
                    o_cmd.out_sel = OUT_FULL;
                    n_state       = ST_EMIT;
                end else if (i_sts.at_end || (i_sts.idx_zero && i_sts.key_gt) ||
                             (!i_sts.idx_zero && !i_sts.key_lt)) begin
                    o_cmd.insert  = 1'b1;
                    o_cmd.out_sel = OUT_DONE;
                    n_state       = ST_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_CNT: begin
                if (i_sts.at_end) begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.out_sel = OUT_COUNT;
                    n_state       = ST_EMIT;
                end else begin
                    o_cmd.cnt_inc = i_sts.time_le;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_LIST: begin
                if (i_sts.at_end) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    if (i_sts.time_le) begin
                        o_cmd.seen_inc = 1'b1;
                        o_cmd.out_sel  = OUT_ENTRY;
                        n_state        = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_state = i_sts.out_last ? ST_IDLE : ST_LIST;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/sevt_datapath.sv */
// Datapath of the sorted event table: entry registers, occupancy, scan counter,
// request and key registers, query counters and the result register. Depends on sevt_pkg.
module sevt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sevt_pkg::TIME_W-1:0]   i_time_value,
    input  logic [sevt_pkg::PID_W-1:0]    i_package_id,
    input  logic                          i_is_registration,
    input  logic [sevt_pkg::REF_W-1:0]    i_event_ref,
    input  sevt_pkg::t_cmd                i_cmd,
    output sevt_pkg::t_sts                o_sts,
    output logic [sevt_pkg::STATUS_W-1:0] o_status,
    output logic [sevt_pkg::CNT_W-1:0]    o_match_count,
    output logic [sevt_pkg::TIME_W-1:0]   o_out_time,
    output logic [sevt_pkg::PID_W-1:0]    o_out_package_id,
    output logic [sevt_pkg::REF_W-1:0]    o_out_event_ref,
    output logic                          o_last
);
    import sevt_pkg::*;

    t_entry              r_ent [TABLE_DEPTH];
    t_entry              n_ent [TABLE_DEPTH];
    t_entry              r_req;
    t_entry              w_cur;
    logic [KEY_W-1:0]    r_key;
    logic [KEY_W-1:0]    w_cur_key;
    logic [OCC_W-1:0]    r_occ;
    logic [OCC_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_seen;
    logic [STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]    r_mcount;
    logic [TIME_W-1:0]   r_otime;
    logic [PID_W-1:0]    r_opid;
    logic [REF_W-1:0]    r_oref;
    logic                r_olast;

    assign w_cur     = r_ent[r_idx[IDX_W-1:0]];
    assign w_cur_key = key_of(w_cur.time_value, w_cur.package_id);

    always_comb begin
        o_sts.at_end   = (r_idx == r_occ);
        o_sts.full     = (r_occ == OCC_W'(TABLE_DEPTH));
        o_sts.idx_zero = (r_idx == '0);
        o_sts.del_hit  = (w_cur.package_id == r_req.package_id) && !w_cur.is_registration;
        o_sts.key_lt   = (w_cur_key < r_key);
        o_sts.key_gt   = (w_cur_key > r_key);
        o_sts.time_le  = (w_cur.time_value <= r_req.time_value);
        o_sts.out_last = r_olast;
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            n_ent[i] = r_ent[i];
        end
        if (i_cmd.insert) begin
            if (r_idx == '0) begin
                n_ent[0] = r_req;
            end
            for (int i = 1; i < TABLE_DEPTH; i++) begin
                if (OCC_W'(i) == r_idx) begin
                    n_ent[i] = r_req;
                end else if (OCC_W'(i) > r_idx && OCC_W'(i) <= r_occ) begin
                    n_ent[i] = r_ent[i-1];
                end
            end
        end else if (i_cmd.remove) begin
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                if (OCC_W'(i) >= r_idx && OCC_W'(i + 1) < r_occ) begin
                    n_ent[i] = r_ent[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            r_ent[i] <= n_ent[i];
        end
        if (i_cmd.load) begin
            r_req.time_value      <= i_time_value;
            r_req.package_id      <= i_package_id;
            r_req.is_registration <= i_is_registration;
            r_req.event_ref       <= i_event_ref;
            r_key                 <= key_of(i_time_value, i_package_id);
        end
        case (i_cmd.out_sel)
            OUT_DONE, OUT_FULL: begin
                r_status <= (i_cmd.out_sel == OUT_FULL) ? STATUS_FULL : STATUS_DONE;
                r_mcount <= '0;
                r_otime  <= '0;
                r_opid   <= '0;
                r_oref   <= '0;
                r_olast  <= 1'b1;
            end
            OUT_COUNT: begin
                r_status <= STATUS_QUERY;
                r_mcount <= r_cnt;
                r_otime  <= '0;
                r_opid   <= '0;
                r_oref   <= '0;
                r_olast  <= (r_cnt == '0);
            end
            OUT_ENTRY: begin
                r_status <= STATUS_QUERY;
                r_mcount <= r_cnt;
                r_otime  <= w_cur.time_value;
                r_opid   <= w_cur.package_id;
                r_oref   <= w_cur.event_ref;
                r_olast  <= ((r_seen + CNT_W'(1)) == r_cnt);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_idx  <= '0;
            r_cnt  <= '0;
            r_seen <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (i_cmd.remove) begin
                r_occ <= r_occ - OCC_W'(1);
            end
            if (i_cmd.load || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + OCC_W'(1);
            end
            if (i_cmd.load) begin
                r_cnt  <= '0;
                r_seen <= '0;
            end else begin
                if (i_cmd.cnt_inc) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (i_cmd.seen_inc) begin
                    r_seen <= r_seen + CNT_W'(1);
                end
            end
        end
    end

    assign o_status         = r_status;
    assign o_match_count    = r_mcount;
    assign o_out_time       = r_otime;
    assign o_out_package_id = r_opid;
    assign o_out_event_ref  = r_oref;
    assign o_last           = r_olast;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for sorted_event_table: random and directed insert, update, query and undefined-kind traffic,
// checked transfer by transfer against an ordered table kept in the bench.
// Depends on sevt_pkg, sevt_in_if, sevt_out_if and the sorted_event_table RTL.
module tb_top;
    import sevt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNDEFINED = 2'd3;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 53;
    localparam int PRINT_LIMIT   = 30;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] time_value;
        logic [PID_W-1:0]  package_id;
        logic              is_registration;
        logic [REF_W-1:0]  event_ref;
    } t_table_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    match_count;
        logic [TIME_W-1:0]   out_time;
        logic [PID_W-1:0]    out_package_id;
        logic [REF_W-1:0]    out_event_ref;
        logic                last;
    } t_table_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sevt_in_if  req_ch ();
    sevt_out_if rsp_ch ();

    sorted_event_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_table_request pending_requests[$];
    t_table_result  expected_results[$];
    t_table_request request_on_bus;

    t_entry slots[TABLE_DEPTH];
    int     slot_fill = 0;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatch_count     = 0;
    int cycle_count        = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] order_key(input logic [TIME_W-1:0] t,
                                                   input logic [PID_W-1:0] p);
        logic [KEY_W-1:0] k;
        k = KEY_W'(t);
        k = k * KEY_W'(KEY_SCALE) + KEY_W'(p);
        return k;
    endfunction

    function automatic t_table_result make_result(input logic [STATUS_W-1:0] status,
                                                  input logic [CNT_W-1:0] cnt,
                                                  input t_entry e, input logic last);
        t_table_result r;
        r.status         = status;
        r.match_count    = cnt;
        r.out_time       = e.time_value;
        r.out_package_id = e.package_id;
        r.out_event_ref  = e.event_ref;
        r.last           = last;
        return r;
    endfunction

    task automatic predict_table_op(input t_table_request rq);
        t_entry           blank;
        t_entry           fresh;
        logic [KEY_W-1:0] k;
        int               found;
        int               pos;
        int               cnt;
        int               seen;
        blank = '0;
        if (rq.kind == KIND_INSERT || rq.kind == KIND_UPDATE) begin
            if (rq.kind == KIND_UPDATE) begin
                found = -1;
                for (int i = 0; i < slot_fill; i++) begin
                    if (found < 0 && slots[i].package_id == rq.package_id &&
                        !slots[i].is_registration) begin
                        found = i;
                    end
                end
                if (found >= 0) begin
                    for (int i = found; i < slot_fill - 1; i++) begin
                        slots[i] = slots[i + 1];
                    end
                    slot_fill--;
                end
            end
            if (slot_fill >= TABLE_DEPTH) begin
                expected_results.push_back(make_result(STATUS_FULL, '0, blank, 1'b1));
            end else begin
                k = order_key(rq.time_value, rq.package_id);
                // An equal-keyed head keeps its place; elsewhere the new entry goes first.
                if (slot_fill == 0 ||
                    order_key(slots[0].time_value, slots[0].package_id) > k) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < slot_fill &&
                           order_key(slots[pos].time_value, slots[pos].package_id) < k) begin
                        pos++;
                    end
                end
                for (int i = slot_fill; i > pos; i--) begin
                    slots[i] = slots[i - 1];
                end
                fresh.time_value      = rq.time_value;
                fresh.package_id      = rq.package_id;
                fresh.is_registration = rq.is_registration;
                fresh.event_ref       = rq.event_ref;
                slots[pos] = fresh;
                slot_fill++;
                expected_results.push_back(make_result(STATUS_DONE, '0, blank, 1'b1));
            end
        end else if (rq.kind == KIND_QUERY) begin
            cnt = 0;
            for (int i = 0; i < slot_fill; i++) begin
                if (slots[i].time_value <= rq.time_value) begin
                    cnt++;
                end
            end
            expected_results.push_back(make_result(STATUS_QUERY, CNT_W'(cnt), blank, cnt == 0));
            seen = 0;
            for (int i = 0; i < slot_fill; i++) begin
                if (slots[i].time_value <= rq.time_value) begin
                    seen++;
                    expected_results.push_back(make_result(STATUS_QUERY, CNT_W'(cnt), slots[i],
                                                           seen == cnt));
                end
            end
        end else begin
            expected_results.push_back(make_result(STATUS_DONE, '0, blank, 1'b1));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic push_request(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] t,
                                input logic [PID_W-1:0] p, input logic reg_flag,
                                input logic [REF_W-1:0] handle);
        t_table_request rq;
        rq.kind            = kind;
        rq.time_value      = t;
        rq.package_id      = p;
        rq.is_registration = reg_flag;
        rq.event_ref       = handle;
        pending_requests.push_back(rq);
    endtask

    task automatic push_random_request();
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] t;
        logic [PID_W-1:0]  p;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 42) begin
            kind = KIND_INSERT;
        end else if (pick < 72) begin
            kind = KIND_UPDATE;
        end else if (pick < 94) begin
            kind = KIND_QUERY;
        end else begin
            kind = KIND_UNDEFINED;
        end
        pick = $urandom_range(99);
        if (kind == KIND_QUERY) begin
            if (pick < 50) begin
                t = TIME_W'($urandom_range(0, 45));
            end else if (pick < 65) begin
                t = '1;
            end else if (pick < 75) begin
                t = '0;
            end else begin
                t = TIME_W'($urandom());
            end
        end else begin
            if (pick < 70) begin
                t = TIME_W'($urandom_range(0, 40));
            end else if (pick < 85) begin
                t = TIME_W'($urandom());
            end else begin
                t = 24'hFFFFFF - TIME_W'($urandom_range(0, 3));
            end
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            p = PID_W'($urandom_range(0, 7));
        end else if (pick < 90) begin
            p = PID_W'($urandom_range(0, 9999));
        end else begin
            p = PID_W'($urandom_range(10000, 16383));
        end
        push_request(kind, t, p, $urandom_range(99) < 30, REF_W'($urandom_range(0, 65535)));
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : count_cycles
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive_requests
        t_table_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_table_op(request_on_bus);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    request_on_bus <= nxt;
                    req_ch.kind            <= nxt.kind;
                    req_ch.time_value      <= nxt.time_value;
                    req_ch.package_id      <= nxt.package_id;
                    req_ch.is_registration <= nxt.is_registration;
                    req_ch.event_ref       <= nxt.event_ref;
                    req_ch.valid           <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_table_result want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, status", 32'(rsp_ch.status),
                                    32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                    if (rsp_ch.match_count !== want.match_count)
                        report_mismatch("match_count", 32'(rsp_ch.match_count),
                                        32'(want.match_count));
                    if (rsp_ch.out_time !== want.out_time)
                        report_mismatch("out_time", 32'(rsp_ch.out_time), 32'(want.out_time));
                    if (rsp_ch.out_package_id !== want.out_package_id)
                        report_mismatch("out_package_id", 32'(rsp_ch.out_package_id),
                                        32'(want.out_package_id));
                    if (rsp_ch.out_event_ref !== want.out_event_ref)
                        report_mismatch("out_event_ref", 32'(rsp_ch.out_event_ref),
                                        32'(want.out_event_ref));
                    if (rsp_ch.last !== want.last)
                        report_mismatch("last", 32'(rsp_ch.last), 32'(want.last));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin : run_test
        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.kind            = '0;
        req_ch.time_value      = '0;
        req_ch.package_id      = '0;
        req_ch.is_registration = 1'b0;
        req_ch.event_ref       = '0;
        rsp_ch.ready           = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct    = 9;
        receiver_stall_pct = 61;

        // Query and undefined kind on the empty table, then an update with nothing to remove.
        push_request(KIND_QUERY, 24'd0, 14'd0, 1'b0, 16'h0000);
        push_request(KIND_UNDEFINED, 24'hFFFFFF, 14'h3FFF, 1'b1, 16'hFFFF);
        push_request(KIND_UPDATE, 24'd10, 14'd5, 1'b0, 16'h0001);
        // Equal keys: behind the head, then in front of the other equal entry.
        push_request(KIND_INSERT, 24'd10, 14'd5, 1'b1, 16'hFFFF);
        push_request(KIND_INSERT, 24'd10, 14'd5, 1'b0, 16'h1234);
        push_request(KIND_INSERT, 24'd0, 14'd0, 1'b0, 16'h0000);
        push_request(KIND_INSERT, 24'd0, 14'd0, 1'b0, 16'h00FF);
        push_request(KIND_INSERT, 24'hFFFFFF, 14'd9999, 1'b0, 16'hAAAA);
        push_request(KIND_INSERT, 24'hFFFFFF, 14'h3FFF, 1'b1, 16'h5555);
        // An out-of-range id runs into the next time step of the key: time 9, id 16383 sorts after time 10, id 5.
        push_request(KIND_INSERT, 24'd9, 14'h3FFF, 1'b0, 16'h0F0F);
        push_request(KIND_QUERY, 24'd9, 14'd0, 1'b0, 16'h0000);
        push_request(KIND_QUERY, 24'd10, 14'd0, 1'b0, 16'h0000);
        push_request(KIND_UPDATE, 24'd3, 14'd5, 1'b0, 16'hF0F0);
        push_request(KIND_UPDATE, 24'd20, 14'd7, 1'b1, 16'h7777);
        push_request(KIND_UPDATE, 24'd21, 14'd7, 1'b0, 16'h7778);
        push_request(KIND_UPDATE, 24'd22, 14'd7, 1'b0, 16'h7779);
        push_request(KIND_QUERY, 24'hFFFFFE, 14'h3FFF, 1'b1, 16'hFFFF);
        push_request(KIND_QUERY, 24'hFFFFFF, 14'd0, 1'b0, 16'h0000);
        push_request(KIND_INSERT, 24'h800000, 14'h2000, 1'b1, 16'h8000);
        push_request(KIND_QUERY, 24'h7FFFFF, 14'd0, 1'b0, 16'h0000);
        push_request(KIND_UNDEFINED, 24'd0, 14'd0, 1'b0, 16'h0000);
        push_request(KIND_QUERY, 24'hFFFFFF, 14'd0, 1'b0, 16'h0000);
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 0) begin
                sender_idle_pct    = 9;
                receiver_stall_pct = 61;
            end else if (phase == 1) begin
                sender_idle_pct    = 61;
                receiver_stall_pct = 9;
            end else begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                push_random_request();
            end
            wait_for_drain();
        end

        repeat (150) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
